FILE: rtl/bkrl_pkg.sv
// ----------------------------------------------------------------------------
// bkrl_pkg
// Types and constants shared by the bounded nearest-neighbor result list.
// ----------------------------------------------------------------------------
package bkrl_pkg;

   localparam int unsigned OP_W    = 2;
   localparam int unsigned POINT_W = 16;
   localparam int unsigned DIST_W  = 32;
   localparam int unsigned POS_W   = 4;
   localparam int unsigned CFG_W   = 5;

   localparam logic [CFG_W-1:0]  K_RESET   = 5'd16;
   localparam logic [DIST_W-1:0] DIST_ONES = '1;

   typedef enum logic [OP_W-1:0] {
      OP_START = 2'd0,
      OP_OFFER = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic               start;
      logic               offer;
      logic               read;
      logic [DIST_W-1:0]  cand_dist;
      logic [POINT_W-1:0] cand_point;
      logic [POS_W-1:0]   position;
   } cell_ctrl_type;

   // per-cell taps, OR-merged at the top level
   typedef struct packed {
      logic               ins;
      logic [DIST_W-1:0]  last_dist;
      logic [DIST_W-1:0]  rd_dist;
      logic [POINT_W-1:0] rd_point;
   } cell_tap_type;

endpackage

FILE: rtl/bkrl_cell.sv
// ----------------------------------------------------------------------------
// bkrl_cell
// One slot of the sorted list. Compares its distance against the offered one,
// passes its entry to the right-hand neighbor on a shift and takes the left
// neighbor's entry or the candidate.
// ----------------------------------------------------------------------------
module bkrl_cell
   import bkrl_pkg::*;
#(
   parameter int unsigned IDX = 0,
   parameter int unsigned KW  = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  cell_ctrl_type      ctrl,
   input  logic [KW-1:0]      held,
   input  logic [KW-1:0]      k,
   input  logic [DIST_W-1:0]  left_dist,
   input  logic [POINT_W-1:0] left_point,
   input  logic               left_move,
   output logic [DIST_W-1:0]  slot_dist,
   output logic [POINT_W-1:0] point,
   output logic               move,
   output cell_tap_type       tap
);

   logic [DIST_W-1:0]  dist_ff, dist_in;
   logic [POINT_W-1:0] point_ff, point_in;
   logic               lt_n, eq_n, in_k, is_last, rd_sel, ins;

   assign lt_n    = 32'(IDX) < 32'(held);
   assign eq_n    = 32'(IDX) == 32'(held);
   assign in_k    = 32'(IDX) < 32'(k);
   assign is_last = 32'(IDX) == (32'(k) - 32'd1);
   assign rd_sel  = ctrl.read && lt_n && (32'(ctrl.position) == 32'(IDX));

   assign move = lt_n && (dist_ff > ctrl.cand_dist);

   always_comb begin
      dist_in  = dist_ff;
      point_in = point_ff;
      ins      = 1'b0;
      if (ctrl.offer && in_k) begin
         if (left_move) begin
            dist_in  = left_dist;
            point_in = left_point;
         end else if (move || eq_n) begin
            dist_in  = ctrl.cand_dist;
            point_in = ctrl.cand_point;
            ins      = 1'b1;
         end
      end
      if (ctrl.start && is_last) begin
         dist_in = DIST_ONES;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff <= DIST_ONES;
      end else begin
         dist_ff <= dist_in;
      end
      point_ff <= point_in;
   end

   assign slot_dist = dist_ff;
   assign point     = point_ff;

   assign tap.ins       = ins;
   assign tap.last_dist = is_last ? dist_in : '0;
   assign tap.rd_dist   = rd_sel ? dist_ff : '0;
   assign tap.rd_point  = rd_sel ? point_ff : '0;

endmodule

FILE: rtl/bounded_knn_result_list.sv
// ----------------------------------------------------------------------------
// bounded_knn_result_list
// Sorted list of the k nearest candidates of one query, held in a row of
// compare-and-shift cells.
// ----------------------------------------------------------------------------
// The rsp_valid strobe is registered: it rises in the cycle after accept.
// Throughput: one word per cycle; an insert is a single parallel
//   compare-and-shift step across the cell row.
// busy is high only while reset is asserted.
// Reset (synchronous): list empty, query index 0, distances all-ones, k = 16.
// The receiver cannot stall; every result is shown for exactly one cycle.
module bounded_knn_result_list
   import bkrl_pkg::*;
#(
   parameter int unsigned CAPACITY = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [OP_W-1:0]                      req_op,
   input  logic [POINT_W-1:0]                   req_query_point,
   input  logic [POINT_W-1:0]                   req_cand_point,
   input  logic [DIST_W-1:0]                    req_cand_distance,
   input  logic [POS_W-1:0]                     req_position,
   output logic                                 rsp_valid,
   output logic [$clog2(CAPACITY+1)-1:0]        rsp_held,
   output logic [DIST_W-1:0]                    rsp_worst_distance,
   output logic                                 rsp_stored,
   output logic [POINT_W-1:0]                   rsp_entry_point,
   output logic [DIST_W-1:0]                    rsp_entry_distance,
   output logic                                 rsp_entry_valid,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [CFG_W-1:0]                     csr_data
);

   localparam int unsigned KW = $clog2(CAPACITY + 1);

   logic               accept;
   op_type             op;
   logic [CFG_W-1:0]   k_cfg_ff;
   logic [KW-1:0]      k, held, fill_ff, fill_in, held_after;
   logic [POINT_W-1:0] query_ff, query_in;
   cell_ctrl_type      ctrl;
   logic               offer_ok;

   logic [DIST_W-1:0]  dist_w  [CAPACITY];
   logic [POINT_W-1:0] point_w [CAPACITY];
   logic               move_w  [CAPACITY];
   cell_tap_type       tap_w   [CAPACITY];
   cell_tap_type       tap_or;

   logic               rsp_valid_ff;
   logic [KW-1:0]      rsp_held_ff;
   logic [DIST_W-1:0]  rsp_worst_ff, worst_in;
   logic               rsp_stored_ff, entry_valid_in, rsp_entry_valid_ff;
   logic [POINT_W-1:0] rsp_entry_point_ff;
   logic [DIST_W-1:0]  rsp_entry_distance_ff;

   assign busy      = reset;
   assign csr_ready = !reset;
   assign accept    = start && !busy;
   assign op        = op_type'(req_op);

   always_comb begin
      if (k_cfg_ff == '0) begin
         k = KW'(1);
      end else if (32'(k_cfg_ff) > CAPACITY) begin
         k = KW'(CAPACITY);
      end else begin
         k = KW'(k_cfg_ff);
      end
   end

   assign held     = (fill_ff < k) ? fill_ff : k;
   assign offer_ok = accept && (op == OP_OFFER) && (req_cand_point < query_ff);

   always_comb begin
      ctrl.start      = accept && (op == OP_START);
      ctrl.offer      = offer_ok;
      ctrl.read       = accept && (op == OP_READ);
      ctrl.cand_dist  = req_cand_distance;
      ctrl.cand_point = req_cand_point;
      ctrl.position   = req_position;
   end

   always_comb begin
      fill_in  = fill_ff;
      query_in = query_ff;
      if (ctrl.start) begin
         fill_in  = '0;
         query_in = req_query_point;
      end else if (offer_ok) begin
         fill_in = (held < k) ? held + KW'(1) : k;
      end
   end

   assign held_after = (fill_in < k) ? fill_in : k;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DIST_W-1:0]  l_dist;
      logic [POINT_W-1:0] l_point;
      logic               l_move;
      if (g == 0) begin : g_head
         assign l_dist  = DIST_ONES;
         assign l_point = '0;
         assign l_move  = 1'b0;
      end else begin : g_body
         assign l_dist  = dist_w[g-1];
         assign l_point = point_w[g-1];
         assign l_move  = move_w[g-1];
      end
      bkrl_cell #(
         .IDX (g),
         .KW  (KW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .held       (held),
         .k          (k),
         .left_dist  (l_dist),
         .left_point (l_point),
         .left_move  (l_move),
         .slot_dist  (dist_w[g]),
         .point      (point_w[g]),
         .move       (move_w[g]),
         .tap        (tap_w[g])
      );
   end

   always_comb begin
      tap_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         tap_or = tap_or | tap_w[i];
      end
   end

   assign worst_in       = (held_after == k) ? tap_or.last_dist : DIST_ONES;
   assign entry_valid_in = ctrl.read && (32'(req_position) < 32'(held));

   always_ff @(posedge clock) begin
      if (reset) begin
         k_cfg_ff     <= K_RESET;
         fill_ff      <= '0;
         query_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            k_cfg_ff <= csr_data;
         end
         fill_ff      <= fill_in;
         query_ff     <= query_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_held_ff           <= held_after;
         rsp_worst_ff          <= worst_in;
         rsp_stored_ff         <= offer_ok && tap_or.ins;
         rsp_entry_valid_ff    <= entry_valid_in;
         rsp_entry_point_ff    <= tap_or.rd_point;
         rsp_entry_distance_ff <= tap_or.rd_dist;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_held           = rsp_held_ff;
   assign rsp_worst_distance = rsp_worst_ff;
   assign rsp_stored         = rsp_stored_ff;
   assign rsp_entry_valid    = rsp_entry_valid_ff;
   assign rsp_entry_point    = rsp_entry_point_ff;
   assign rsp_entry_distance = rsp_entry_distance_ff;

   a_rsp_follows_accept : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("result strobe missing after accepted word");

   a_no_spurious_rsp : assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_valid)
      else $error("result strobe without accepted word");

   a_held_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_held) <= CAPACITY))
      else $error("held count beyond capacity");

   a_stored_from_offer : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stored) |-> ($past(req_op) == OP_OFFER) && (rsp_held != '0))
      else $error("stored flag without offer or with empty list");

   a_entry_from_read : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_entry_valid) |-> ($past(req_op) == OP_READ))
      else $error("entry valid without read");

endmodule

FILE: tb/sv/tb_bounded_knn_result_list.sv
// ----------------------------------------------------------------------------
// tb_bounded_knn_result_list
// Self-checking bench for the bounded nearest-neighbor result list: drives
// start, offer, read and unused-op words, predicts every reply with its own
// sorted-list model and compares each reply field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bounded_knn_result_list;
   import bkrl_pkg::*;

   localparam int unsigned CAP = 16;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [4:0]         held;
      logic [DIST_W-1:0]  worst;
      logic               stored;
      logic [POINT_W-1:0] entry_point;
      logic [DIST_W-1:0]  entry_dist;
      logic               entry_valid;
   } knn_reply_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [OP_W-1:0]      req_op;
   logic [POINT_W-1:0]   req_query_point;
   logic [POINT_W-1:0]   req_cand_point;
   logic [DIST_W-1:0]    req_cand_distance;
   logic [POS_W-1:0]     req_position;
   logic                 rsp_valid;
   logic [4:0]           rsp_held;
   logic [DIST_W-1:0]    rsp_worst_distance;
   logic                 rsp_stored;
   logic [POINT_W-1:0]   rsp_entry_point;
   logic [DIST_W-1:0]    rsp_entry_distance;
   logic                 rsp_entry_valid;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CFG_W-1:0]     csr_data;

   // predictor state
   logic [CFG_W-1:0]     k_setting;
   logic [POINT_W-1:0]   query_idx;
   int unsigned          fill_cnt;
   logic [DIST_W-1:0]    list_dist[CAP];
   logic [POINT_W-1:0]   list_point[CAP];

   knn_reply_type        pending_replies[$];
   int unsigned          mismatch_count;
   int unsigned          sender_gap_pct;
   logic [POINT_W-1:0]   cur_query;

   bounded_knn_result_list #(.CAPACITY(CAP)) dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_query_point    (req_query_point),
      .req_cand_point     (req_cand_point),
      .req_cand_distance  (req_cand_distance),
      .req_position       (req_position),
      .rsp_valid          (rsp_valid),
      .rsp_held           (rsp_held),
      .rsp_worst_distance (rsp_worst_distance),
      .rsp_stored         (rsp_stored),
      .rsp_entry_point    (rsp_entry_point),
      .rsp_entry_distance (rsp_entry_distance),
      .rsp_entry_valid    (rsp_entry_valid),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("[bounded_knn_result_list] ERROR");
      $finish;
   end

   function automatic int unsigned active_k();
      int unsigned k;
      k = 32'(k_setting);
      if (k < 1) k = 1;
      if (k > CAP) k = CAP;
      return k;
   endfunction

   function automatic void predict_reply(logic [OP_W-1:0] op, logic [POINT_W-1:0] qp,
                                         logic [POINT_W-1:0] cp, logic [DIST_W-1:0] cd,
                                         logic [POS_W-1:0] pos);
      knn_reply_type r;
      int unsigned   k;
      int unsigned   n;
      int unsigned   i;
      int unsigned   held;
      k = active_k();
      r.stored = 1'b0;
      r.entry_point = '0;
      r.entry_dist = '0;
      r.entry_valid = 1'b0;
      case (op)
         OP_START: begin
            query_idx = qp;
            fill_cnt = 0;
            list_dist[k-1] = DIST_ONES;
         end
         OP_OFFER: begin
            if (cp < query_idx) begin
               n = (fill_cnt < k) ? fill_cnt : k;
               i = n;
               // shift larger entries down, new one lands after equal distances
               while (i > 0 && list_dist[i-1] > cd) begin
                  if (i < k) begin
                     list_dist[i] = list_dist[i-1];
                     list_point[i] = list_point[i-1];
                  end
                  i--;
               end
               if (i < k) begin
                  list_dist[i] = cd;
                  list_point[i] = cp;
                  r.stored = 1'b1;
               end
               fill_cnt = (n < k) ? n + 1 : k;
            end
         end
         default: ;
      endcase
      held = (fill_cnt < k) ? fill_cnt : k;
      if (op == OP_READ && pos < held) begin
         r.entry_valid = 1'b1;
         r.entry_point = list_point[pos];
         r.entry_dist = list_dist[pos];
      end
      r.held = held[4:0];
      r.worst = (held == k) ? list_dist[k-1] : DIST_ONES;
      pending_replies.push_back(r);
   endfunction

   function automatic void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // reply checker and predictor; the predictor samples at the accepting edge
   always @(posedge clock) begin
      knn_reply_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_replies.size() == 0) begin
               $display("%0t unexpected reply word: expected none, actual held %h",
                        $time, rsp_held);
               mismatch_count++;
            end else begin
               want = pending_replies.pop_front();
               field_check("held", 32'(want.held), 32'(rsp_held));
               field_check("worst_distance", want.worst, rsp_worst_distance);
               field_check("stored", 32'(want.stored), 32'(rsp_stored));
               field_check("entry_point", 32'(want.entry_point), 32'(rsp_entry_point));
               field_check("entry_distance", want.entry_dist, rsp_entry_distance);
               field_check("entry_valid", 32'(want.entry_valid), 32'(rsp_entry_valid));
            end
         end
         if (csr_valid && csr_ready)
            k_setting = csr_data;
         if (start && !busy)
            predict_reply(req_op, req_query_point, req_cand_point, req_cand_distance,
                          req_position);
      end
   end

   task automatic send_word(logic [OP_W-1:0] op, logic [POINT_W-1:0] qp,
                            logic [POINT_W-1:0] cp, logic [DIST_W-1:0] cd,
                            logic [POS_W-1:0] pos);
      if ($urandom_range(99) < sender_gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start             <= 1'b1;
      req_op            <= op;
      req_query_point   <= qp;
      req_cand_point    <= cp;
      req_cand_distance <= cd;
      req_position      <= pos;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic send_start(logic [POINT_W-1:0] qp);
      cur_query = qp;
      send_word(OP_START, qp, 16'($urandom()), $urandom(), 4'($urandom()));
   endtask

   task automatic send_offer(logic [POINT_W-1:0] cp, logic [DIST_W-1:0] cd);
      send_word(OP_OFFER, 16'($urandom()), cp, cd, 4'($urandom()));
   endtask

   task automatic send_read(logic [POS_W-1:0] pos);
      send_word(OP_READ, 16'($urandom()), 16'($urandom()), $urandom(), pos);
   endtask

   task automatic drain_replies();
      start <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_count(logic [CFG_W-1:0] value);
      drain_replies();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_empty_and_extremes();
      send_read(4'd0);
      send_offer(16'd0, 32'd5);             // query 0: nothing is below it
      send_word(OP_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 4'hF);
      send_start(16'hFFFF);
      send_offer(16'hFFFF, 32'd7);          // not below query
      send_offer(16'hFFFE, 32'hFFFF_FFFF);
      send_offer(16'h0000, 32'h0000_0000);
      send_offer(16'd100, 32'd50);
      send_offer(16'd200, 32'd50);
      send_offer(16'd300, 32'd50);
      for (int p = 0; p < 5; p++) send_read(p[3:0]);
      send_read(4'd15);
      send_start(16'd1);
      send_offer(16'd0, 32'd9);
      send_read(4'd0);
      send_start(16'd0);
      send_offer(16'd0, 32'd1);
      send_read(4'd0);
      drain_replies();
   endtask

   task automatic test_count_settings();
      logic [CFG_W-1:0] counts[8];
      int unsigned      k;
      counts = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd16, 5'd5, 5'd0};
      counts[7] = 5'($urandom_range(0, 31));
      foreach (counts[c]) begin
         write_count(counts[c]);
         k = (counts[c] == 0) ? 1 : (32'(counts[c]) > CAP) ? CAP : 32'(counts[c]);
         send_start(16'h8000);
         for (int j = 0; j < k + 4; j++)
            send_offer(16'($urandom_range(0, 16'h7FFF)), $urandom_range(0, 7));
         for (int p = 0; p < CAP; p++) send_read(p[3:0]);
      end
      // shrink and regrow k in the middle of a query
      write_count(5'd16);
      send_start(16'hC000);
      for (int j = 0; j < 10; j++)
         send_offer(16'($urandom_range(0, 16'hBFFF)), $urandom_range(0, 20));
      write_count(5'd3);
      for (int p = 0; p < 4; p++) send_read(p[3:0]);
      send_offer(16'd12, 32'd0);
      write_count(5'd8);
      for (int p = 0; p < 9; p++) send_read(p[3:0]);
      send_offer(16'd13, 32'd4);
      send_read(4'd3);
      write_count(5'd16);
      drain_replies();
   endtask

   task automatic test_random_traffic(int unsigned words, int unsigned gap_pct);
      int unsigned      sent;
      int unsigned      sel;
      logic [POINT_W-1:0] cp;
      logic [DIST_W-1:0]  cd;
      logic [CFG_W-1:0]   counts[10];
      counts = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd8, 5'd16, 5'd17, 5'd31, 5'd16};
      sender_gap_pct = gap_pct;
      sent = 0;
      while (sent < words) begin
         if ($urandom_range(99) < 2) begin
            counts[9] = 5'($urandom_range(0, 31));
            write_count(counts[$urandom_range(0, 9)]);
         end else if ($urandom_range(99) < 2) begin
            drain_replies();
         end
         sel = $urandom_range(99);
         if (sel < 4) begin
            send_start(16'(sel == 0 ? $urandom_range(0, 40) : $urandom()));
         end else if (sel < 70) begin
            if (cur_query != 0 && $urandom_range(9) != 0)
               cp = 16'($urandom_range(0, cur_query - 1));
            else cp = 16'($urandom());
            case ($urandom_range(0, 5))
               0: cd = $urandom();
               1: cd = DIST_ONES;
               2: cd = '0;
               default: cd = $urandom_range(0, 31);
            endcase
            send_offer(cp, cd);
         end else if (sel < 96) begin
            send_read(4'($urandom()));
         end else begin
            send_word(OP_UNUSED, 16'($urandom()), 16'($urandom()), $urandom(),
                      4'($urandom()));
         end
         sent++;
      end
      drain_replies();
   endtask

   initial begin
      int unsigned waited;
      reset             <= 1'b1;
      start             <= 1'b0;
      req_op            <= OP_START;
      req_query_point   <= '0;
      req_cand_point    <= '0;
      req_cand_distance <= '0;
      req_position      <= '0;
      csr_valid         <= 1'b0;
      csr_data          <= K_RESET;
      k_setting         = K_RESET;
      query_idx         = '0;
      fill_cnt          = 0;
      cur_query         = '0;
      mismatch_count    = 0;
      sender_gap_pct    = 0;
      foreach (list_dist[i]) begin
         list_dist[i]  = DIST_ONES;
         list_point[i] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_empty_and_extremes();
      test_count_settings();
      test_random_traffic(620, 28);
      test_random_traffic(620, 84);
      test_random_traffic(610, 0);

      start <= 1'b0;
      waited = 0;
      while (pending_replies.size() != 0 && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && pending_replies.size() == 0) begin
         $display("[bounded_knn_result_list] OK");
      end else begin
         if (pending_replies.size() != 0)
            $display("%0t missing replies: expected 0 pending, actual %0d", $time,
                     pending_replies.size());
         $display("[bounded_knn_result_list] ERROR");
      end
      $finish;
   end

endmodule

FILE: bounded_knn_result_list.f
rtl/bkrl_pkg.sv
rtl/bkrl_cell.sv
rtl/bounded_knn_result_list.sv
tb/sv/tb_bounded_knn_result_list.sv
